### rtl/core/tun_pkg.sv
// triangle unit normal: transaction types and fixed datapath widths
package tun_pkg;

    localparam int FIELD_W = 16;
    localparam int MAG_W   = 31;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;

    typedef struct packed {
        logic signed [FIELD_W-1:0] ax;
        logic signed [FIELD_W-1:0] ay;
        logic signed [FIELD_W-1:0] az;
        logic signed [FIELD_W-1:0] bx;
        logic signed [FIELD_W-1:0] by;
        logic signed [FIELD_W-1:0] bz;
        logic signed [FIELD_W-1:0] cx;
        logic signed [FIELD_W-1:0] cy;
        logic signed [FIELD_W-1:0] cz;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] norm_x;
        logic signed [FIELD_W-1:0] norm_y;
        logic signed [FIELD_W-1:0] norm_z;
        logic                      degenerate;
    } t_out_item;

endpackage

### rtl/core/triangle_unit_normal.sv
// triangle unit normal: edges, cross product, square root and division pipeline
//
// Input channel i_valid/o_ready carries one triangle (three Q8.8 vertices) per
// transaction; output channel o_valid/i_ready carries the Q1.14 unit normal and
// the degenerate flag. One result per triangle, in order.
// Throughput: one transaction per cycle unless the output stalls. Every stage
// holds one triangle; the 32-bit square root takes one result bit per stage
// (32 stages) and each of the three restoring dividers takes one quotient bit
// per stage (OUT_FRAC_BITS+1).
// The whole pipeline advances together: when the output register holds a
// result that is not taken, o_ready drops and every stage holds its contents,
// so nothing is lost or repeated; a bubble in the output register lets the
// pipe move even while i_ready is low.
// Reset clears all stage valid bits; data registers are not reset.
module triangle_unit_normal #(
    parameter int COORD_WIDTH   = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  tun_pkg::t_in_item   i_data,
    output logic                o_ready,
    output logic                o_valid,
    output tun_pkg::t_out_item  o_data,
    input  logic                i_ready
);

    localparam int FW  = tun_pkg::FIELD_W;
    localparam int MSW = tun_pkg::MAG_W;
    localparam int RW  = tun_pkg::ROOT_W;
    localparam int SW  = tun_pkg::SUM_W;
    localparam int CW  = COORD_WIDTH;
    localparam int ESH = (CW > 30) ? CW - 30 : 0;
    localparam int EW  = ((CW > 30) ? 30 : CW) + 1;
    localparam int PW  = 2 * EW;
    localparam int CXW = PW + 1;
    localparam int MW  = PW;
    localparam int KW  = $clog2(MW + 1);
    localparam int F   = OUT_FRAC_BITS;
    localparam int QW  = F + 1;
    localparam int DW  = RW + F + 1;
    localparam int NSQ = RW;
    localparam int OW  = (QW > FW) ? QW : FW;

    typedef struct packed {
        logic [2:0][MSW-1:0] m;
        logic [2:0]          neg;
        logic                deg;
    } t_side;

    function automatic logic [CW-1:0] coord(logic [FW-1:0] f);
        return CW'(f);
    endfunction

    function automatic logic signed [EW-1:0] edge_of(logic [CW-1:0] a, logic [CW-1:0] b);
        logic [CW:0]          d;
        logic [CW:0]          mag;
        logic [CW:0]          sh;
        logic signed [EW-1:0] e_val;
        d     = {b[CW-1], b} - {a[CW-1], a};
        mag   = d[CW] ? (~d + 1'b1) : d;
        sh    = mag >> ESH;
        e_val = EW'(sh);
        return d[CW] ? -e_val : e_val;
    endfunction

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // stage 1: edges
    logic [CW-1:0] c_a [3];
    logic [CW-1:0] c_b [3];
    logic [CW-1:0] c_c [3];
    always_comb begin
        c_a[0] = coord(i_data.ax);
        c_a[1] = coord(i_data.ay);
        c_a[2] = coord(i_data.az);
        c_b[0] = coord(i_data.bx);
        c_b[1] = coord(i_data.by);
        c_b[2] = coord(i_data.bz);
        c_c[0] = coord(i_data.cx);
        c_c[1] = coord(i_data.cy);
        c_c[2] = coord(i_data.cz);
    end

    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [PW-1:0] r_p  [6];
    logic [2:0][MW-1:0]   r_mag3;
    logic [2:0]           r_neg3;
    logic [2:0][MW-1:0]   r_mag4;
    logic [2:0]           r_neg4;
    logic [KW-1:0]        r_k4;
    logic                 r_deg4;
    t_side                r_sd5;
    logic [2:0][2*MSW-1:0] r_q6;
    t_side                r_sd6;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    logic [SW-1:0] r_sq_s  [NSQ+1];
    logic [SW-1:0] r_sq_r  [NSQ+1];
    t_side         r_sq_sd [NSQ+1];
    logic [NSQ:0]  r_sq_v;

    logic [2:0][DW-1:0] r_dv_rem [QW+1];
    logic [2:0][QW-1:0] r_dv_q   [QW+1];
    logic [RW-1:0]      r_dv_len [QW+1];
    logic [2:0]         r_dv_neg [QW+1];
    logic               r_dv_deg [QW+1];
    logic [QW:0]        r_dv_v;

    tun_pkg::t_out_item r_out;
    logic               r_out_v;

    // stage 3 and 4 combinational parts
    logic [CXW-1:0]     n_cx [3];
    logic [2:0][MW-1:0] n_mag3;
    logic [MW-1:0]      n_orv;
    logic [KW-1:0]      n_bl;
    logic [KW-1:0]      n_k;
    always_comb begin
        n_cx[0] = {r_p[0][PW-1], r_p[0]} - {r_p[1][PW-1], r_p[1]};
        n_cx[1] = {r_p[2][PW-1], r_p[2]} - {r_p[3][PW-1], r_p[3]};
        n_cx[2] = {r_p[4][PW-1], r_p[4]} - {r_p[5][PW-1], r_p[5]};
        for (int i = 0; i < 3; i++) begin
            n_mag3[i] = n_cx[i][CXW-1] ? MW'(~n_cx[i] + 1'b1) : MW'(n_cx[i]);
        end
        n_orv = r_mag3[0] | r_mag3[1] | r_mag3[2];
        n_bl  = '0;
        for (int i = 0; i < MW; i++) begin
            if (n_orv[i]) n_bl = KW'(i + 1);
        end
        n_k = (n_bl > KW'(MSW)) ? n_bl - KW'(MSW) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= edge_of(c_a[i], c_b[i]);
                r_e2[i] <= edge_of(c_a[i], c_c[i]);
            end
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e2[1] * r_e1[2];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e2[2] * r_e1[0];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e2[0] * r_e1[1];
            r_mag3 <= n_mag3;
            for (int i = 0; i < 3; i++) begin
                r_neg3[i] <= n_cx[i][CXW-1];
            end
            r_mag4 <= r_mag3;
            r_neg4 <= r_neg3;
            r_k4   <= n_k;
            r_deg4 <= (n_orv == '0);
            for (int i = 0; i < 3; i++) begin
                r_sd5.m[i] <= MSW'(r_mag4[i] >> r_k4);
            end
            r_sd5.neg <= r_neg4;
            r_sd5.deg <= r_deg4;
            for (int i = 0; i < 3; i++) begin
                r_q6[i] <= r_sd5.m[i] * r_sd5.m[i];
            end
            r_sd6 <= r_sd5;
            r_sq_s[0]  <= SW'(r_q6[0]) + SW'(r_q6[1]) + SW'(r_q6[2]);
            r_sq_r[0]  <= '0;
            r_sq_sd[0] <= r_sd6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_v6      <= 1'b0;
            r_sq_v    <= '0;
            r_dv_v    <= '0;
            r_out_v   <= 1'b0;
        end else if (en) begin
            r_v1      <= i_valid;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_v6      <= r_v5;
            r_sq_v    <= {r_sq_v[NSQ-1:0], r_v6};
            r_dv_v    <= {r_dv_v[QW-1:0], r_sq_v[NSQ]};
            r_out_v   <= r_dv_v[QW];
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (NSQ - 1 - j));
        logic [SW-1:0] n_t;
        logic          n_ge;
        assign n_t  = r_sq_r[j] + BIT;
        assign n_ge = r_sq_s[j] >= n_t;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_s[j+1]  <= n_ge ? r_sq_s[j] - n_t : r_sq_s[j];
                r_sq_r[j+1]  <= n_ge ? (r_sq_r[j] >> 1) + BIT : r_sq_r[j] >> 1;
                r_sq_sd[j+1] <= r_sq_sd[j];
            end
        end
    end

    // divider setup: rounded numerators
    logic [RW-1:0] n_len;
    assign n_len = (r_sq_r[NSQ][RW-1:0] == '0) ? RW'(1) : r_sq_r[NSQ][RW-1:0];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= (DW'(r_sq_sd[NSQ].m[i]) << F) + DW'(n_len >> 1);
            end
            r_dv_q[0]   <= '0;
            r_dv_len[0] <= n_len;
            r_dv_neg[0] <= r_sq_sd[NSQ].neg;
            r_dv_deg[0] <= r_sq_sd[NSQ].deg;
        end
    end

    // restoring dividers, one quotient bit per stage, three lanes
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int QB = QW - 1 - j;
        logic [DW-1:0] n_dvs;
        assign n_dvs = DW'(r_dv_len[j]) << QB;
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic n_ge;
            assign n_ge = r_dv_rem[j][l] >= n_dvs;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_rem[j+1][l] <= n_ge ? r_dv_rem[j][l] - n_dvs : r_dv_rem[j][l];
                    r_dv_q[j+1][l]   <= n_ge ? r_dv_q[j][l] | (QW'(1) << QB) : r_dv_q[j][l];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_len[j+1] <= r_dv_len[j];
                r_dv_neg[j+1] <= r_dv_neg[j];
                r_dv_deg[j+1] <= r_dv_deg[j];
            end
        end
    end

    // saturate, apply sign, output register
    logic [2:0][OW-1:0] n_sat;
    logic [2:0][FW-1:0] n_res;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sat[i] = (r_dv_q[QW][i] > (QW'(1) << F)) ? (OW'(1) << F) : OW'(r_dv_q[QW][i]);
            n_res[i] = r_dv_neg[QW][i] ? FW'(~n_sat[i] + 1'b1) : FW'(n_sat[i]);
            if (r_dv_deg[QW]) n_res[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.norm_x     <= n_res[0];
            r_out.norm_y     <= n_res[1];
            r_out.norm_z     <= n_res[2];
            r_out.degenerate <= r_dv_deg[QW];
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

### rtl/core/tun_check.sv
// triangle unit normal: port-level checker and its bind
module tun_check #(
    parameter int OUT_FRAC_BITS = 14
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input tun_pkg::t_out_item o_data,
    input logic               i_ready
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output transaction dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("output payload changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output backpressure");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |->
            (o_data.norm_x == '0) && (o_data.norm_y == '0) && (o_data.norm_z == '0))
        else $error("degenerate result with nonzero normal");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.degenerate |-> (OUT_FRAC_BITS > 14) ||
            (o_data.norm_x != '0) || (o_data.norm_y != '0) || (o_data.norm_z != '0))
        else $error("valid triangle gave a zero normal");

endmodule

bind triangle_unit_normal tun_check #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_tun_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_ready (i_ready)
);
